FILE: sv/hash_set_engine_core_defines.svh
// Assertion macros for the hash set engine.
`ifndef HASH_SET_ENGINE_CORE_DEFINES_SVH
`define HASH_SET_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define HSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/hse_pkg.sv
`timescale 1ns / 1ps

package hse_pkg;

  localparam int KEY_W       = 32;
  localparam int COUNT_W     = 9;
  // four rounds of h*31 + byte stay below 2**23
  localparam int HASH_W      = 23;
  localparam int BUCKETS_DEF = 64;
  localparam int WAYS_DEF    = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_INS  = 2'd1,
    WR_ERS  = 2'd2,
    WR_CLR  = 2'd3
  } wr_kind_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic signed [KEY_W-1:0]   key;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic                      bucket_full;
    logic [COUNT_W-1:0]        entry_count;
  } rsp_t;

  typedef struct packed {
    logic act;
    logic match_seen;
    logic free_seen;
  } chain_t;

  function automatic logic [HASH_W-1:0] key_hash(input logic [KEY_W-1:0] k);
    logic [HASH_W-1:0] h;
    h = '0;
    for (int b = 0; b < 4; b++) begin
      h = (h << 5) - h + HASH_W'(k[8*b +: 8]);
    end
    return h;
  endfunction

endpackage

FILE: sv/hse_hash.sv
`timescale 1ns / 1ps

module hse_hash import hse_pkg::*; #(
  parameter int  BUCKETS  = BUCKETS_DEF,
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KEY_W-1:0]    key,
  output logic                done,
  output logic [BUCKET_W-1:0] bucket
);

  // exact floor(h / BUCKETS) for any HASH_W-bit h via rounded-up reciprocal
  localparam int          SHIFT   = HASH_W + BUCKET_W;
  localparam int          RECIP_W = HASH_W + 2;
  localparam int          PROD_W  = HASH_W + RECIP_W;
  localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

  logic [HASH_W-1:0] h_q;
  logic [HASH_W-1:0] q_q;
  logic [2:0]        stg;
  logic [PROD_W-1:0] prod;
  logic [HASH_W-1:0] qb;
  logic [HASH_W-1:0] rem;

  assign prod = PROD_W'(h_q) * PROD_W'(RECIP);
  assign qb   = q_q * HASH_W'(BUCKETS);
  assign rem  = h_q - qb;
  assign done = stg[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg <= '0;
    end else begin
      stg <= {stg[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h_q <= key_hash(key);
    end
    if (stg[0]) begin
      q_q <= HASH_W'(prod >> SHIFT);
    end
    if (stg[1]) begin
      bucket <= rem[BUCKET_W-1:0];
    end
  end

endmodule

FILE: sv/hse_cell.sv
`timescale 1ns / 1ps

module hse_cell import hse_pkg::*; #(
  parameter int  BUCKETS  = BUCKETS_DEF,
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [BUCKET_W-1:0] addr,
  input  logic [KEY_W-1:0]    key,
  input  wr_kind_t            wr_kind,
  input  chain_t              chain_in,
  output chain_t              chain_out
);

  logic [KEY_W-1:0] key_mem [BUCKETS];
  logic             vld_mem [BUCKETS];
  logic [KEY_W-1:0] key_rd;
  logic             vld_rd;
  logic             my_match;
  logic             my_free;
  logic             eq;
  logic             ins_here;
  logic             vld_we;

  assign eq       = vld_rd && (key_rd == key);
  assign ins_here = (wr_kind == WR_INS) && my_free;
  assign vld_we   = ins_here || ((wr_kind == WR_ERS) && my_match) || (wr_kind == WR_CLR);

  always_ff @(posedge clk) begin
    key_rd <= key_mem[addr];
    if (ins_here) begin
      key_mem[addr] <= key;
    end
  end

  always_ff @(posedge clk) begin
    vld_rd <= vld_mem[addr];
    if (vld_we) begin
      vld_mem[addr] <= (wr_kind == WR_INS);
    end
  end

  // first matching way and first free way claim themselves as the word passes
  always_ff @(posedge clk) begin
    if (chain_in.act) begin
      my_match <= eq && !chain_in.match_seen;
      my_free  <= !vld_rd && !chain_in.free_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_out <= '0;
    end else begin
      chain_out.act        <= chain_in.act;
      chain_out.match_seen <= chain_in.match_seen || eq;
      chain_out.free_seen  <= chain_in.free_seen || !vld_rd;
    end
  end

endmodule

FILE: sv/hash_set_engine_core.sv
// channel | signals                      | word
// --------+------------------------------+--------------------------------
// req     | req_valid, req_ready, req    | opcode, key
// rsp     | rsp_valid, rsp_ready, rsp    | hit, bucket_full, entry_count
//
// Insert, erase and find pass from accept through the hash and reciprocal
// bucket reduction and a row read, then the compare word walks the chain of
// way cells, registered in each, before the engine takes the next request.
// Clear sweeps every bucket, one bucket row cleared per cycle.
// After reset a clearing pass over every bucket runs with req_ready low.
// A pending response holds the engine in its final state; insert and erase
// write the table only when the response is loaded.
`timescale 1ns / 1ps
`include "hash_set_engine_core_defines.svh"

module hash_set_engine_core import hse_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_HASH   = 8'b0000_0100,
    ST_FETCH  = 8'b0000_1000,
    ST_LAUNCH = 8'b0001_0000,
    ST_SCAN   = 8'b0010_0000,
    ST_SWEEP  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [BUCKET_W-1:0]  sweep_addr;
  opcode_t              op_q;
  logic [KEY_W-1:0]     key_q;
  logic                 match_q;
  logic                 free_q;
  logic [COUNT_W-1:0]   held_count;
  logic [COUNT_W-1:0]   held_count_next;

  logic                 accept;
  logic                 out_free;
  logic                 finish;
  logic                 sweeping;
  logic                 sweep_last;
  logic                 ins_ok;
  logic                 ers_ok;
  logic                 hash_done;
  logic [BUCKET_W-1:0]  bucket;
  logic [BUCKET_W-1:0]  addr;
  wr_kind_t             wr_kind;
  chain_t               links [WAYS+1];

  assign req_ready  = (state == ST_IDLE);
  assign accept     = req_valid && req_ready;
  assign out_free   = !rsp_valid || rsp_ready;
  assign finish     = (state == ST_DONE) && out_free;
  assign sweeping   = (state == ST_INIT) || (state == ST_SWEEP);
  assign sweep_last = (sweep_addr == BUCKET_W'(BUCKETS - 1));
  assign ins_ok     = (op_q == OP_INSERT) && !match_q && free_q;
  assign ers_ok     = (op_q == OP_ERASE) && match_q;
  assign addr       = sweeping ? sweep_addr : bucket;

  hse_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && (req.opcode != OP_CLEAR)),
    .key    (req.key),
    .done   (hash_done),
    .bucket (bucket)
  );

  assign links[0] = '{act: (state == ST_LAUNCH), match_seen: 1'b0, free_seen: 1'b0};

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    hse_cell #(.BUCKETS(BUCKETS)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .addr      (addr),
      .key       (key_q),
      .wr_kind   (wr_kind),
      .chain_in  (links[w]),
      .chain_out (links[w+1])
    );
  end

  always_comb begin
    wr_kind = WR_NONE;
    if (sweeping) begin
      wr_kind = WR_CLR;
    end else if (finish && ins_ok) begin
      wr_kind = WR_INS;
    end else if (finish && ers_ok) begin
      wr_kind = WR_ERS;
    end
  end

  always_comb begin
    held_count_next = held_count;
    if (finish) begin
      if (op_q == OP_CLEAR) begin
        held_count_next = '0;
      end else if (ins_ok) begin
        held_count_next = held_count + COUNT_W'(1);
      end else if (ers_ok) begin
        held_count_next = held_count - COUNT_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = (req.opcode == OP_CLEAR) ? ST_SWEEP : ST_HASH;
      end
      ST_HASH: begin
        if (hash_done) state_next = ST_FETCH;
      end
      ST_FETCH:  state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_SCAN;
      ST_SCAN: begin
        if (links[WAYS].act) state_next = ST_DONE;
      end
      ST_SWEEP: begin
        if (sweep_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      sweep_addr <= '0;
      held_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      if (accept) begin
        sweep_addr <= '0;
      end else if (sweeping) begin
        sweep_addr <= sweep_addr + BUCKET_W'(1);
      end
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.opcode;
      key_q <= req.key;
    end
    if ((state == ST_SCAN) && links[WAYS].act) begin
      match_q <= links[WAYS].match_seen;
      free_q  <= links[WAYS].free_seen;
    end
    if (finish) begin
      rsp.hit         <= ins_ok || ers_ok || ((op_q == OP_FIND) && match_q);
      rsp.bucket_full <= (op_q == OP_INSERT) && !match_q && !free_q;
      rsp.entry_count <= held_count_next;
    end
  end

  `HSE_ASSERT_NOW(a_hit_full_excl, rsp_valid, !(rsp.hit && rsp.bucket_full), "hit with bucket_full")
  `HSE_ASSERT_NEXT(a_count_hold, state != ST_DONE, $stable(held_count), "count moved outside done")
  `HSE_ASSERT_NOW(a_chain_tail, links[WAYS].act, state == ST_SCAN, "chain word outside scan")
  `HSE_ASSERT_NOW(a_hash_done, hash_done, state == ST_HASH, "bucket ready outside hash wait")
  `HSE_ASSERT_NOW(a_table_write, (wr_kind == WR_INS) || (wr_kind == WR_ERS), finish, "table write without response load")

endmodule
